// File: rtl/gps_track_interpolator_macros.svh
// Assertion macros shared by the GPS track interpolator RTL.
`ifndef GPS_TRACK_INTERPOLATOR_MACROS_SVH
`define GPS_TRACK_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define GTI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define GTI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define GTI_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/gti_pkg.sv
// Shared types, widths and codes for the GPS track interpolator.
package gti_pkg;

    localparam int TRACK_DEPTH_DEF = 1024;

    localparam int TIME_W  = 48;
    localparam int LAT_W   = 31;
    localparam int LNG_W   = 32;
    localparam int HALF_W  = TIME_W / 2;
    localparam int REC_W   = TIME_W + LAT_W + LNG_W;
    localparam int QBITS   = 41;
    localparam int SDATA_W = ((TIME_W + LAT_W + LNG_W + 7) / 8) * 8;
    localparam int MDATA_W = ((LAT_W + LNG_W + 7) / 8) * 8;

    localparam int LAT_LIM = 900000000;
    localparam int LNG_LIM = 1800000000;

    typedef enum logic [1:0] {
        ST_POS     = 2'd0,
        ST_NODATA  = 2'd1,
        ST_STORED  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        RA_ZERO,
        RA_LAST,
        RA_CUR,
        RA_CUR1,
        RA_CUR2
    } raddr_sel_t;

    typedef enum logic [2:0] {
        RS_NONE,
        RS_STORED,
        RS_FULL,
        RS_NODATA,
        RS_RD,
        RS_SEG0,
        RS_LANES
    } res_sel_t;

    typedef struct packed {
        logic       capture;
        logic       wr_en;
        res_sel_t   res_sel;
        raddr_sel_t raddr_sel;
        logic       cur_adv;
        logic       load_s0;
        logic       load_s1;
        logic       seg_prep;
        logic       mul_lo;
        logic       mul_hi;
        logic       sum;
        logic       div_init;
        logic       div_step;
        logic       emit;
    } gti_cmd_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic t_le_rd;
        logic t_ge_rd;
        logic walk_more;
        logic seg_zero;
        logic out_free;
    } gti_stat_t;

endpackage

// File: rtl/gti_ram.sv
// Generic simple dual-port RAM with registered read.
module gti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/gti_lane.sv
// One coordinate lane: multiply, bit-serial divide and saturating add.
module gti_lane #(
    parameter int W   = 31,
    parameter int LIM = 900000000
) (
    input  logic                          clk,
    input  gti_pkg::gti_cmd_t             cmd,
    input  logic signed [W-1:0]           v0,
    input  logic signed [W-1:0]           v1,
    input  logic                          back,
    input  logic [gti_pkg::TIME_W-1:0]    off,
    input  logic [gti_pkg::TIME_W-1:0]    dt,
    output logic signed [W-1:0]           res
);

    localparam int TW = gti_pkg::TIME_W;
    localparam int HW = gti_pkg::HALF_W;
    localparam int QB = gti_pkg::QBITS;
    localparam int PW = TW + W;
    localparam int SW = QB + 2;
    localparam logic [QB-1:0]        QCAP  = QB'(1) << (QB - 1);
    localparam logic signed [SW-1:0] LIM_P = SW'(LIM);
    localparam logic signed [SW-1:0] LIM_N = -SW'(LIM);

    logic signed [W:0]      delta;
    logic [W-1:0]           mag;
    logic                   neg;
    logic [HW-1:0]          mul_a;
    logic [HW+W-1:0]        mul_p;
    logic [HW+W-1:0]        lo_reg;
    logic [HW+W-1:0]        hi_reg;
    logic [PW-1:0]          prod_reg;
    logic [TW-1:0]          rem_reg;
    logic [QB-1:0]          sh_reg;
    logic [QB-1:0]          q_reg;
    logic                   cap_reg;
    logic [TW:0]            trial;
    logic [TW-1:0]          hi_part;
    logic [QB-1:0]          qc;
    logic signed [SW-1:0]   qc_s;
    logic signed [SW-1:0]   v0_s;
    logic signed [SW-1:0]   acc;

    assign delta = (W+1)'(v1) - (W+1)'(v0);
    assign mag   = delta[W] ? W'(-delta) : W'(delta);
    assign neg   = delta[W] ^ back;

    // one 24-bit slice of the offset at a time through a single multiplier
    assign mul_a = cmd.mul_hi ? off[TW-1:HW] : off[HW-1:0];
    assign mul_p = (HW+W)'(mul_a) * (HW+W)'(mag);

    assign hi_part = TW'(prod_reg[PW-1:QB]);
    assign trial   = {rem_reg, sh_reg[QB-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
        begin
            lo_reg <= mul_p;
        end
        if (cmd.mul_hi)
        begin
            hi_reg <= mul_p;
        end
        if (cmd.sum)
        begin
            prod_reg <= PW'(lo_reg) + (PW'(hi_reg) << HW);
        end
        if (cmd.div_init)
        begin
            // quotient reaches 2^QB exactly when the top part is not below the divisor
            cap_reg <= hi_part >= dt;
            rem_reg <= hi_part;
            sh_reg  <= prod_reg[QB-1:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, dt})
            begin
                rem_reg <= TW'(trial - {1'b0, dt});
                q_reg   <= {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[TW-1:0];
                q_reg   <= {q_reg[QB-2:0], 1'b0};
            end
            sh_reg <= {sh_reg[QB-2:0], 1'b0};
        end
    end

    assign qc   = (cap_reg || (q_reg > QCAP)) ? QCAP : q_reg;
    assign qc_s = signed'(SW'(qc));
    assign v0_s = SW'(v0);
    assign acc  = neg ? (v0_s - qc_s) : (v0_s + qc_s);

    always_comb
    begin
        if (acc > LIM_P)
        begin
            res = W'(LIM_P);
        end
        else if (acc < LIM_N)
        begin
            res = W'(LIM_N);
        end
        else
        begin
            res = W'(acc);
        end
    end

endmodule

// File: rtl/gti_ctrl.sv
// Request sequencer for the GPS track interpolator.
module gti_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gti_pkg::gti_stat_t  stat,
    output gti_pkg::gti_cmd_t   cmd
);

    localparam int CNTW = $clog2(gti_pkg::QBITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIRST,
        S_LAST,
        S_CUR,
        S_WALK,
        S_SEG,
        S_MULLO,
        S_MULHI,
        S_SUM,
        S_DIVINIT,
        S_DIV,
        S_RESOLVE,
        S_FIN
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CNTW-1:0] div_cnt_reg;
    logic [CNTW-1:0] div_cnt_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.req == gti_pkg::REQ_LOAD)
                begin
                    cmd.wr_en   = !stat.full;
                    cmd.res_sel = stat.full ? gti_pkg::RS_FULL : gti_pkg::RS_STORED;
                    state_next  = S_FIN;
                end
                else if (stat.empty)
                begin
                    cmd.res_sel = gti_pkg::RS_NODATA;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.raddr_sel = gti_pkg::RA_ZERO;
                    state_next    = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (stat.t_le_rd)
                begin
                    cmd.res_sel = gti_pkg::RS_RD;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.raddr_sel = gti_pkg::RA_LAST;
                    state_next    = S_LAST;
                end
            end
            S_LAST:
            begin
                if (stat.t_ge_rd)
                begin
                    cmd.res_sel = gti_pkg::RS_RD;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.raddr_sel = gti_pkg::RA_CUR;
                    state_next    = S_CUR;
                end
            end
            S_CUR:
            begin
                cmd.load_s0   = 1'b1;
                cmd.raddr_sel = gti_pkg::RA_CUR1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (stat.walk_more)
                begin
                    cmd.cur_adv   = 1'b1;
                    cmd.load_s0   = 1'b1;
                    cmd.raddr_sel = gti_pkg::RA_CUR2;
                end
                else
                begin
                    cmd.load_s1 = 1'b1;
                    state_next  = S_SEG;
                end
            end
            S_SEG:
            begin
                if (stat.seg_zero)
                begin
                    cmd.res_sel = gti_pkg::RS_SEG0;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.seg_prep = 1'b1;
                    state_next   = S_MULLO;
                end
            end
            S_MULLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MULHI;
            end
            S_MULHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DIVINIT;
            end
            S_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + CNTW'(1);
                if (div_cnt_reg == CNTW'(gti_pkg::QBITS - 1))
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                cmd.res_sel = gti_pkg::RS_LANES;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// File: rtl/gti_datapath.sv
// Datapath: sample table, segment registers, lanes and output register.
`include "gps_track_interpolator_macros.svh"

module gti_datapath #(
    parameter int TRACK_DEPTH = gti_pkg::TRACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gti_pkg::gti_cmd_t             cmd,
    output gti_pkg::gti_stat_t            stat,
    input  logic [gti_pkg::SDATA_W-1:0]   s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [gti_pkg::MDATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                    m_axis_tuser
);

    localparam int TW = gti_pkg::TIME_W;
    localparam int AW = $clog2(TRACK_DEPTH);
    localparam int CW = AW + 1;

    gti_pkg::req_t              req_reg;
    logic [TW-1:0]              t_reg;
    logic signed [gti_pkg::LAT_W-1:0] lat_in_reg;
    logic signed [gti_pkg::LNG_W-1:0] lng_in_reg;

    logic [CW-1:0]              count_reg;
    logic [AW-1:0]              cursor_reg;
    logic [CW-1:0]              cur_ext;
    logic [CW-1:0]              last_idx;

    logic [TW-1:0]              s0_t_reg;
    logic signed [gti_pkg::LAT_W-1:0] s0_lat_reg;
    logic signed [gti_pkg::LNG_W-1:0] s0_lng_reg;
    logic [TW-1:0]              s1_t_reg;
    logic signed [gti_pkg::LAT_W-1:0] s1_lat_reg;
    logic signed [gti_pkg::LNG_W-1:0] s1_lng_reg;

    logic                       back_reg;
    logic [TW-1:0]              off_reg;
    logic [TW-1:0]              dt_reg;

    gti_pkg::status_t           res_status_reg;
    logic signed [gti_pkg::LAT_W-1:0] res_lat_reg;
    logic signed [gti_pkg::LNG_W-1:0] res_lng_reg;

    logic                       out_valid_reg;
    gti_pkg::status_t           out_status_reg;
    logic signed [gti_pkg::LAT_W-1:0] out_lat_reg;
    logic signed [gti_pkg::LNG_W-1:0] out_lng_reg;

    logic [AW-1:0]              rd_addr;
    logic [gti_pkg::REC_W-1:0]  rd_data;
    logic [TW-1:0]              rd_t;
    logic signed [gti_pkg::LAT_W-1:0] rd_lat;
    logic signed [gti_pkg::LNG_W-1:0] rd_lng;
    logic signed [gti_pkg::LAT_W-1:0] lane_lat;
    logic signed [gti_pkg::LNG_W-1:0] lane_lng;
    logic                       full;

    assign full     = count_reg == CW'(TRACK_DEPTH);
    assign cur_ext  = {1'b0, cursor_reg};
    assign last_idx = count_reg - CW'(1);

    always_comb
    begin
        case (cmd.raddr_sel)
            gti_pkg::RA_ZERO: rd_addr = '0;
            gti_pkg::RA_LAST: rd_addr = last_idx[AW-1:0];
            gti_pkg::RA_CUR:  rd_addr = cursor_reg;
            gti_pkg::RA_CUR1: rd_addr = cursor_reg + AW'(1);
            gti_pkg::RA_CUR2: rd_addr = cursor_reg + AW'(2);
            default:          rd_addr = '0;
        endcase
    end

    gti_ram #(
        .WIDTH (gti_pkg::REC_W),
        .DEPTH (TRACK_DEPTH)
    ) u_track_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({lng_in_reg, lat_in_reg, t_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_t   = rd_data[TW-1:0];
    assign rd_lat = rd_data[TW +: gti_pkg::LAT_W];
    assign rd_lng = rd_data[TW + gti_pkg::LAT_W +: gti_pkg::LNG_W];

    assign stat.req       = req_reg;
    assign stat.full      = full;
    assign stat.empty     = count_reg == '0;
    assign stat.t_le_rd   = t_reg <= rd_t;
    assign stat.t_ge_rd   = t_reg >= rd_t;
    assign stat.walk_more = ((cur_ext + CW'(2)) < count_reg) && (rd_t < t_reg);
    assign stat.seg_zero  = s1_t_reg <= s0_t_reg;
    assign stat.out_free  = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.cur_adv)
            begin
                cursor_reg <= cursor_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg    <= gti_pkg::req_t'(s_axis_tuser);
            t_reg      <= s_axis_tdata[TW-1:0];
            lat_in_reg <= s_axis_tdata[TW +: gti_pkg::LAT_W];
            lng_in_reg <= s_axis_tdata[TW + gti_pkg::LAT_W +: gti_pkg::LNG_W];
        end
        if (cmd.load_s0)
        begin
            s0_t_reg   <= rd_t;
            s0_lat_reg <= rd_lat;
            s0_lng_reg <= rd_lng;
        end
        if (cmd.load_s1)
        begin
            s1_t_reg   <= rd_t;
            s1_lat_reg <= rd_lat;
            s1_lng_reg <= rd_lng;
        end
        if (cmd.seg_prep)
        begin
            back_reg <= t_reg < s0_t_reg;
            off_reg  <= (t_reg < s0_t_reg) ? (s0_t_reg - t_reg) : (t_reg - s0_t_reg);
            dt_reg   <= s1_t_reg - s0_t_reg;
        end
        case (cmd.res_sel)
            gti_pkg::RS_STORED:
            begin
                res_status_reg <= gti_pkg::ST_STORED;
                res_lat_reg    <= '0;
                res_lng_reg    <= '0;
            end
            gti_pkg::RS_FULL:
            begin
                res_status_reg <= gti_pkg::ST_FULL;
                res_lat_reg    <= '0;
                res_lng_reg    <= '0;
            end
            gti_pkg::RS_NODATA:
            begin
                res_status_reg <= gti_pkg::ST_NODATA;
                res_lat_reg    <= '0;
                res_lng_reg    <= '0;
            end
            gti_pkg::RS_RD:
            begin
                res_status_reg <= gti_pkg::ST_POS;
                res_lat_reg    <= rd_lat;
                res_lng_reg    <= rd_lng;
            end
            gti_pkg::RS_SEG0:
            begin
                res_status_reg <= gti_pkg::ST_POS;
                res_lat_reg    <= s0_lat_reg;
                res_lng_reg    <= s0_lng_reg;
            end
            gti_pkg::RS_LANES:
            begin
                res_status_reg <= gti_pkg::ST_POS;
                res_lat_reg    <= lane_lat;
                res_lng_reg    <= lane_lng;
            end
            default:
            begin
            end
        endcase
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_lat_reg    <= res_lat_reg;
            out_lng_reg    <= res_lng_reg;
        end
    end

    gti_lane #(
        .W   (gti_pkg::LAT_W),
        .LIM (gti_pkg::LAT_LIM)
    ) u_lat_lane (
        .clk  (clk),
        .cmd  (cmd),
        .v0   (s0_lat_reg),
        .v1   (s1_lat_reg),
        .back (back_reg),
        .off  (off_reg),
        .dt   (dt_reg),
        .res  (lane_lat)
    );

    gti_lane #(
        .W   (gti_pkg::LNG_W),
        .LIM (gti_pkg::LNG_LIM)
    ) u_lng_lane (
        .clk  (clk),
        .cmd  (cmd),
        .v0   (s0_lng_reg),
        .v1   (s1_lng_reg),
        .back (back_reg),
        .off  (off_reg),
        .dt   (dt_reg),
        .res  (lane_lng)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = gti_pkg::MDATA_W'({out_lng_reg, out_lat_reg});

    `GTI_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(TRACK_DEPTH), "sample count past depth")
    `GTI_ASSERT(a_cursor_bound, clk, rst_n, (count_reg < CW'(2)) || ((cur_ext + CW'(2)) <= count_reg), "cursor beyond last segment")
    `GTI_ASSERT_IMPL(a_write_room, clk, rst_n, cmd.wr_en, !full, "write into full table")
    `GTI_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, (!out_valid_reg || m_axis_tready), "result overwrites undelivered output")
    `GTI_ASSERT_IMPL(a_zero_pos, clk, rst_n, (out_valid_reg && (out_status_reg != gti_pkg::ST_POS)), ((out_lat_reg == '0) && (out_lng_reg == '0)), "position not zero on non-position status")

endmodule

// File: rtl/gps_track_interpolator.sv
// GPS track interpolator top level: stream ports, sequencer and datapath.
//
// Keeps a table of up to TRACK_DEPTH GPS samples (time in microseconds, latitude and
// longitude in 1e-7 degree) in one block RAM and answers one result per request.
// A load request (tuser 0) appends a sample and answers status 2, or status 3 when the
// table is full and the sample is dropped. A query request (tuser 1) answers status 1
// on an empty table; otherwise it returns the first sample at or before its time, the
// last sample at or after the last time, and in between a linear interpolation over
// the segment chosen by a cursor that only ever moves forward (an earlier query can
// therefore extrapolate; results saturate to the field range). Table contents come up
// undefined after reset; of the table state, only the count and cursor are cleared,
// so there is no clearing pass. One request is in flight at a time, and a finished
// result waits in the output register while the next request is taken. An
// interpolated query walks the cursor forward segment by segment: the walk reads one
// table entry per cycle through the single RAM read port, and the offset-times-delta
// over segment length quotient comes from each lane's own 24-bit by lane-width
// multiplier (two passes) followed by a 41-step restoring divider, both lanes in
// parallel.
module gps_track_interpolator #(
    parameter int TRACK_DEPTH = gti_pkg::TRACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // sample_time [47:0], sample_lat [78:48], sample_lng [110:79], zero [111]
    input  logic [gti_pkg::SDATA_W-1:0]   s_axis_tdata,
    // req_type [0]
    input  logic                          s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_lat [30:0], out_lng [62:31], zero [63]
    output logic [gti_pkg::MDATA_W-1:0]   m_axis_tdata,
    // status [1:0]
    output logic [1:0]                    m_axis_tuser
);

    gti_pkg::gti_cmd_t  cmd;
    gti_pkg::gti_stat_t stat;

    // sequencer: walks each request through decode, table reads, cursor walk,
    // multiply, divide and result hand-off
    gti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: sample table, cursor, two interpolation lanes and output register
    gti_datapath #(
        .TRACK_DEPTH (TRACK_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
